/* hdl/imd_pkg.sv */
// shared types and constants for the integer matrix determinant block
`default_nettype none
package imd_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned SizeW = 4;

  // commands from the controller to the datapath
  typedef struct packed {
    logic mat_we;   // store an incoming element
    logic issue;    // a product term enters the pipeline
    logic neg;      // subtract this term
    logic one;      // minor of the empty column set, read as 1
    logic acc_clr;  // clear the accumulator
    logic dp_we;    // write the finished minor
    logic done;     // present the determinant
  } imd_cmd_t;

endpackage
`default_nettype wire

/* hdl/imd_ctrl.sv */
// controller: load counters, size register and minor sweep sequencer
`default_nettype none
module imd_ctrl import imd_pkg::*; #(
  parameter int unsigned MAX_N = 8,
  parameter int unsigned IDX_W = (MAX_N > 1) ? $clog2(MAX_N) : 1,
  parameter int unsigned AW    = (MAX_N > 1) ? $clog2(MAX_N * MAX_N) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic             cfg_valid_i,
  input  wire logic [SizeW-1:0] cfg_data_i,
  output logic                  cfg_ready_o,
  output logic                  busy_o,
  output imd_cmd_t              cmd_o,
  output logic [AW-1:0]         mat_addr_o,
  output logic [MAX_N-1:0]      dp_raddr_o,
  output logic [MAX_N-1:0]      dp_waddr_o
);

  localparam int unsigned CW = $clog2(MAX_N + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [SizeW-1:0] size_q;
  logic [IDX_W-1:0] row_q, row_d, col_q, col_d, j_q, j_d;
  logic [MAX_N-1:0] set_q, set_d;
  logic             neg_q, neg_d;
  logic [1:0]       drain_q, drain_d;

  logic [SizeW-1:0] n_eff;
  logic [IDX_W-1:0] n_m1;
  logic [MAX_N-1:0] full_set;
  logic [CW-1:0]    pop;
  logic [IDX_W-1:0] scan_row;
  logic [MAX_N-1:0] minor_set;
  logic             member;
  logic             accept;
  logic             cfg_wr;

  always_comb begin
    if (size_q == '0) begin
      n_eff = SizeW'(1);
    end else if (size_q > SizeW'(MAX_N)) begin
      n_eff = SizeW'(MAX_N);
    end else begin
      n_eff = size_q;
    end
    n_m1 = IDX_W'(n_eff - SizeW'(1));
    pop  = '0;
    for (int k = 0; k < MAX_N; k++) begin
      full_set[k] = (k < int'(n_eff));
      pop = pop + CW'(set_q[k]);
    end
    // rows are consumed bottom up as the column set grows
    scan_row  = IDX_W'(n_eff - SizeW'(pop));
    member    = set_q[j_q];
    minor_set = set_q & ~(MAX_N'(1) << j_q);
  end

  assign busy_o      = (state_q != ST_IDLE);
  // an element transfer and a size write never share an edge
  assign cfg_ready_o = !busy_o && !start_i;
  assign accept      = start_i && !busy_o;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign dp_raddr_o  = minor_set;
  assign dp_waddr_o  = set_q;

  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    col_d   = col_q;
    j_d     = j_q;
    set_d   = set_q;
    neg_d   = neg_q;
    drain_d = drain_q;
    cmd_o   = '0;
    mat_addr_o = AW'(int'(row_q) * MAX_N + int'(col_q));
    case (state_q)
      ST_IDLE: begin
        if (cfg_wr) begin
          row_d = '0;
          col_d = '0;
        end else if (accept) begin
          cmd_o.mat_we = 1'b1;
          if (col_q == n_m1) begin
            col_d = '0;
            if (row_q == n_m1) begin
              row_d         = '0;
              cmd_o.acc_clr = 1'b1;
              set_d         = MAX_N'(1);
              j_d           = '0;
              neg_d         = 1'b0;
              state_d       = ST_SCAN;
            end else begin
              row_d = row_q + IDX_W'(1);
            end
          end else begin
            col_d = col_q + IDX_W'(1);
          end
        end
      end
      ST_SCAN: begin
        mat_addr_o = AW'(int'(scan_row) * MAX_N + int'(j_q));
        cmd_o.issue = member;
        cmd_o.neg   = neg_q;
        cmd_o.one   = (minor_set == '0);
        if (member) begin
          neg_d = !neg_q;
        end
        if (j_q == n_m1) begin
          drain_d = '0;
          state_d = ST_DRAIN;
        end else begin
          j_d = j_q + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        drain_d = drain_q + 2'd1;
        if (drain_q == 2'd2) begin
          cmd_o.dp_we   = 1'b1;
          cmd_o.acc_clr = 1'b1;
          if (set_q == full_set) begin
            cmd_o.done = 1'b1;
            state_d    = ST_IDLE;
          end else begin
            set_d   = set_q + MAX_N'(1);
            j_d     = '0;
            neg_d   = 1'b0;
            state_d = ST_SCAN;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      size_q  <= SizeW'(1);
      row_q   <= '0;
      col_q   <= '0;
      j_q     <= '0;
      set_q   <= '0;
      neg_q   <= 1'b0;
      drain_q <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      j_q     <= j_d;
      set_q   <= set_d;
      neg_q   <= neg_d;
      drain_q <= drain_d;
      if (cfg_wr) begin
        size_q <= cfg_data_i;
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/imd_dp.sv */
// datapath: element store, minor table, multiplier and accumulator
`default_nettype none
module imd_dp import imd_pkg::*; #(
  parameter int unsigned MAX_N = 8,
  parameter int unsigned AW    = (MAX_N > 1) ? $clog2(MAX_N * MAX_N) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [DataW-1:0] element_i,
  input  wire imd_cmd_t         cmd_i,
  input  wire logic [AW-1:0]    mat_addr_i,
  input  wire logic [MAX_N-1:0] dp_raddr_i,
  input  wire logic [MAX_N-1:0] dp_waddr_i,
  output logic [DataW-1:0]      determinant_o,
  output logic                  det_valid_o
);

  localparam int unsigned MatDepth = MAX_N * MAX_N;
  localparam int unsigned DpDepth  = 1 << MAX_N;

  logic [DataW-1:0] mat_mem [MatDepth];
  logic [DataW-1:0] dp_mem  [DpDepth];

  logic [DataW-1:0] mat_rd_q, dp_rd_q, prod_q, acc_q, det_q;
  logic             v1_q, neg1_q, one1_q, v2_q, neg2_q, valid_q;
  logic [DataW-1:0] op_b;
  // only the low word of the product matters, arithmetic wraps mod 2^32
  logic [DataW-1:0] prod_lo;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mat_we) begin
      mat_mem[mat_addr_i] <= element_i;
    end
    mat_rd_q <= mat_mem[mat_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.dp_we) begin
      dp_mem[dp_waddr_i] <= acc_q;
    end
    dp_rd_q <= dp_mem[dp_raddr_i];
  end

  assign op_b    = one1_q ? DataW'(1) : dp_rd_q;
  assign prod_lo = mat_rd_q * op_b;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_lo;
    neg1_q <= cmd_i.neg;
    one1_q <= cmd_i.one;
    neg2_q <= neg1_q;
    if (cmd_i.done) begin
      det_q <= acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      valid_q <= 1'b0;
      acc_q   <= '0;
    end else begin
      v1_q    <= cmd_i.issue;
      v2_q    <= v1_q;
      valid_q <= cmd_i.done;
      if (cmd_i.acc_clr) begin
        acc_q <= '0;
      end else if (v2_q) begin
        acc_q <= neg2_q ? (acc_q - prod_q) : (acc_q + prod_q);
      end
    end
  end

  assign determinant_o = det_q;
  assign det_valid_o   = valid_q;

endmodule
`default_nettype wire

/* hdl/integer_matrix_determinant_top.sv */
// top level of the integer matrix determinant block
`default_nettype none
// Elements are taken row by row, one per start while busy_o is low; the
// matrix size (1..MAX_N, 0 reads as 1, larger reads as MAX_N) is written on
// the cfg channel, which also restarts loading and is ready only while both
// busy_o and start_i are low. After the last element the determinant
// (mod 2^32) is built from minors over every column subset, at most one
// product a cycle on a single multiplier, with busy_o high. The result
// appears for one cycle with det_valid_o; the receiver cannot stall it.
module integer_matrix_determinant_top import imd_pkg::*; #(
  parameter int unsigned MAX_N = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  output logic                  busy_o,
  input  wire logic [DataW-1:0] element_i,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [SizeW-1:0] cfg_data_i,
  output logic [DataW-1:0]      determinant_o,
  output logic                  det_valid_o
);

  localparam int unsigned AW = (MAX_N > 1) ? $clog2(MAX_N * MAX_N) : 1;

  imd_cmd_t         cmd;
  logic [AW-1:0]    mat_addr;
  logic [MAX_N-1:0] dp_raddr, dp_waddr;

  imd_ctrl #(.MAX_N(MAX_N)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .busy_o      (busy_o),
    .cmd_o       (cmd),
    .mat_addr_o  (mat_addr),
    .dp_raddr_o  (dp_raddr),
    .dp_waddr_o  (dp_waddr)
  );

  imd_dp #(.MAX_N(MAX_N)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .element_i     (element_i),
    .cmd_i         (cmd),
    .mat_addr_i    (mat_addr),
    .dp_raddr_i    (dp_raddr),
    .dp_waddr_i    (dp_waddr),
    .determinant_o (determinant_o),
    .det_valid_o   (det_valid_o)
  );

endmodule
`default_nettype wire
